// ===== hdl/distance_constraint_solver_unit_assert.svh =====
// assertion macros for the distance constraint solver
// the using scope provides clk and rst_n
`ifndef DISTANCE_CONSTRAINT_SOLVER_UNIT_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_UNIT_ASSERT_SVH

// consequent holds in the same cycle
`define DCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcs assertion failed");

// consequent holds in the next cycle
`define DCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcs assertion failed");

`endif

// ===== hdl/dcs_pkg.sv =====
package dcs_pkg;

    localparam int POS_W  = 32;
    localparam int AXIS_W = 33;
    localparam int MASS_W = 16;
    localparam int LEN_W  = 31;
    localparam int FAC_W  = 16;
    localparam int RF_W   = LEN_W + FAC_W;
    localparam int SQ_W   = 66;
    localparam int ROOT_W = 33;
    localparam int NUM_W  = 66;
    localparam int DEN_W  = 34;
    localparam int QUO_W  = 34;
    localparam int SUM_W  = MASS_W + 1;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    // front 4, sqrt, 3 middle, divide, 1, divide, output 1
    localparam int LATENCY = 4 + SQRT_STEPS + 3 + DIV_STEPS + 1 + DIV_STEPS + 1;

    // geometry carried alongside the square root
    typedef struct packed {
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] ay;
        logic              sx;
        logic              sy;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic [LEN_W-1:0]  rest;
        logic [RF_W-1:0]   rf;
        logic              fac_nz;
        logic              tension;
    } geo_t;

    // decisions carried alongside the first divide
    typedef struct packed {
        logic              nx;
        logic              ny;
        logic              weighted;
        logic              skip;
        logic              broken;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
    } ctl_t;

    // base moves carried alongside the weight divide
    typedef struct packed {
        logic [QUO_W-1:0] tx;
        logic [QUO_W-1:0] ty;
        logic             nx;
        logic             ny;
        logic             weighted;
        logic             skip;
        logic             broken;
    } wgt_t;

    // signed saturation of a sign and magnitude pair
    function automatic logic [POS_W-1:0] sat32(input logic neg, input logic [QUO_W-1:0] mag);
        logic [POS_W-1:0] r;
        if (neg)
        begin
            if (mag[QUO_W-1:POS_W-1] != '0)
                r = {1'b1, {(POS_W-1){1'b0}}};
            else
                r = ~mag[POS_W-1:0] + 1'b1;
        end
        else
        begin
            if (mag[QUO_W-1:POS_W-1] != '0)
                r = {1'b0, {(POS_W-1){1'b1}}};
            else
                r = mag[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/dcs_if.sv =====
interface dcs_link_if import dcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  first_x;
    logic signed [POS_W-1:0]  first_y;
    logic signed [POS_W-1:0]  second_x;
    logic signed [POS_W-1:0]  second_y;
    logic        [MASS_W-1:0] first_mass;
    logic        [MASS_W-1:0] second_mass;
    logic        [LEN_W-1:0]  rest_length;
    logic        [FAC_W-1:0]  max_stretch;
    logic                     tension_only;

    modport source (output valid, first_x, first_y, second_x, second_y, first_mass,
                    second_mass, rest_length, max_stretch, tension_only, input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y, first_mass,
                  second_mass, rest_length, max_stretch, tension_only, output ready);
endinterface

interface dcs_move_if import dcs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] move_first_x;
    logic signed [POS_W-1:0] move_first_y;
    logic signed [POS_W-1:0] move_second_x;
    logic signed [POS_W-1:0] move_second_y;
    logic                    broken;
    logic                    moved;

    modport source (output valid, move_first_x, move_first_y, move_second_x,
                    move_second_y, broken, moved, input ready);
    modport sink (input valid, move_first_x, move_first_y, move_second_x,
                  move_second_y, broken, moved, output ready);
endinterface

// ===== hdl/distance_constraint_solver_unit.sv =====
// channel | role   | payload
// link    | sink   | two positions, two masses, rest length, break factor, tension flag
// move    | source | four saturated moves, broken, moved
//
// one transaction per cycle sustained while the move output is not stalled; 110 register stages,
// most of them in the 33 stage square root and the two 34 stage divide passes
// reset clears only the stage valid bits; the data registers are not reset
// a stalled move output freezes the whole pipeline; no transaction is lost or repeated
`include "distance_constraint_solver_unit_assert.svh"

module distance_constraint_solver_unit import dcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dcs_link_if.sink   link,
    dcs_move_if.source move
);

    logic               en;
    logic [LATENCY-1:0] vld_reg;

    // stage a regs
    logic [AXIS_W-1:0] a_ax_reg, a_ay_reg;
    logic              a_sx_reg, a_sy_reg, a_ten_reg;
    logic [MASS_W-1:0] a_m1_reg, a_m2_reg;
    logic [LEN_W-1:0]  a_rest_reg;
    logic [FAC_W-1:0]  a_fac_reg;
    logic signed [AXIS_W-1:0] vx, vy;

    // stage b/c/d regs
    logic [AXIS_W+16:0] b_pxl_reg, b_pyl_reg;
    logic [AXIS_W+15:0] b_pxh_reg, b_pyh_reg;
    geo_t               b_geo_reg, c_geo_reg, d_geo_reg;
    logic [SQ_W-1:0]    c_sqx_reg, c_sqy_reg, d_rad_reg;
    geo_t               geo_dly_reg [SQRT_STEPS];
    logic [ROOT_W-1:0]  root_len;

    // stage e
    geo_t              e_geo;
    logic              e_brk, e_dneg, e_dpos;
    logic [DEN_W-1:0]  e_delta, e_ad;
    logic [DEN_W-1:0]  e_ad_reg, e_den_reg;
    logic [AXIS_W-1:0] e_ax_reg, e_ay_reg;
    ctl_t              e_ctl_reg;

    // stage f/g
    logic [AXIS_W+16:0] f_pxl_reg, f_pxh_reg, f_pyl_reg, f_pyh_reg;
    logic [DEN_W-1:0]   f_den_reg, g_den_reg;
    ctl_t               f_ctl_reg, g_ctl_reg;
    logic [NUM_W-1:0]   g_numx_reg, g_numy_reg;
    ctl_t               ctl_dly_reg [DIV_STEPS];
    logic [QUO_W-1:0]   tx, ty;
    logic [DEN_W-1:0]   rx_unused, ry_unused;

    // stage h
    ctl_t             h_ctl;
    logic [NUM_W-1:0] h_px_reg, h_py_reg;
    logic [DEN_W-1:0] h_sum_reg;
    wgt_t             h_wgt_reg;
    wgt_t             wgt_dly_reg [DIV_STEPS];
    logic [QUO_W-1:0] qx, qy;
    logic [DEN_W-1:0] rx, ry;

    // stage i
    wgt_t             i_wgt;
    logic [QUO_W-1:0] w1x, w1y, w2x, w2y;
    logic [POS_W-1:0] o_mfx_reg, o_mfy_reg, o_msx_reg, o_msy_reg;
    logic             o_broken_reg, o_moved_reg;
    logic             o_zero;

    // pipeline advances unless the output holds a stalled transaction
    assign en         = move.ready || !vld_reg[LATENCY-1];
    assign link.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LATENCY-2:0], link.valid};
    end

    // stage a: axis differences and magnitudes
    assign vx = {link.first_x[POS_W-1], link.first_x} - {link.second_x[POS_W-1], link.second_x};
    assign vy = {link.first_y[POS_W-1], link.first_y} - {link.second_y[POS_W-1], link.second_y};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ax_reg   <= vx[AXIS_W-1] ? AXIS_W'(-vx) : vx;
            a_ay_reg   <= vy[AXIS_W-1] ? AXIS_W'(-vy) : vy;
            a_sx_reg   <= vx[AXIS_W-1];
            a_sy_reg   <= vy[AXIS_W-1];
            a_m1_reg   <= link.first_mass;
            a_m2_reg   <= link.second_mass;
            a_rest_reg <= link.rest_length;
            a_fac_reg  <= link.max_stretch;
            a_ten_reg  <= link.tension_only;
        end
    end

    // stage b: split squares and break threshold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pxl_reg         <= a_ax_reg * a_ax_reg[16:0];
            b_pxh_reg         <= a_ax_reg * a_ax_reg[AXIS_W-1:17];
            b_pyl_reg         <= a_ay_reg * a_ay_reg[16:0];
            b_pyh_reg         <= a_ay_reg * a_ay_reg[AXIS_W-1:17];
            b_geo_reg.ax      <= a_ax_reg;
            b_geo_reg.ay      <= a_ay_reg;
            b_geo_reg.sx      <= a_sx_reg;
            b_geo_reg.sy      <= a_sy_reg;
            b_geo_reg.m1      <= a_m1_reg;
            b_geo_reg.m2      <= a_m2_reg;
            b_geo_reg.rest    <= a_rest_reg;
            b_geo_reg.rf      <= a_rest_reg * a_fac_reg;
            b_geo_reg.fac_nz  <= a_fac_reg != '0;
            b_geo_reg.tension <= a_ten_reg;
        end
    end

    // stages c and d: assemble squares and their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sqx_reg <= SQ_W'(b_pxl_reg) + SQ_W'({b_pxh_reg, 17'b0});
            c_sqy_reg <= SQ_W'(b_pyl_reg) + SQ_W'({b_pyh_reg, 17'b0});
            c_geo_reg <= b_geo_reg;
            d_rad_reg <= c_sqx_reg + c_sqy_reg;
            d_geo_reg <= c_geo_reg;
        end
    end

    dcs_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (d_rad_reg),
        .root (root_len)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_dly_reg[0] <= d_geo_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
                geo_dly_reg[i] <= geo_dly_reg[i-1];
        end
    end

    // stage e: break test, length error and branch decisions
    assign e_geo   = geo_dly_reg[SQRT_STEPS-1];
    assign e_brk   = e_geo.fac_nz && (RF_W'({root_len, 8'b0}) > e_geo.rf);
    assign e_delta = DEN_W'({1'b0, root_len}) - DEN_W'(e_geo.rest);
    assign e_dneg  = e_delta[DEN_W-1];
    assign e_dpos  = !e_dneg && (e_delta != '0);
    assign e_ad    = e_dneg ? DEN_W'(-e_delta) : e_delta;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_ad_reg           <= e_ad;
            e_den_reg          <= {root_len, 1'b0};
            e_ax_reg           <= e_geo.ax;
            e_ay_reg           <= e_geo.ay;
            e_ctl_reg.nx       <= e_geo.sx ^ e_dneg;
            e_ctl_reg.ny       <= e_geo.sy ^ e_dneg;
            e_ctl_reg.weighted <= (e_geo.m1 != '0) && (e_geo.m2 != '0) && !e_dneg;
            e_ctl_reg.skip     <= e_brk || (root_len == '0) || (e_geo.tension && !e_dpos);
            e_ctl_reg.broken   <= e_brk;
            e_ctl_reg.m1       <= e_geo.m1;
            e_ctl_reg.m2       <= e_geo.m2;
        end
    end

    // stages f and g: split products of axis and length error
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pxl_reg  <= e_ax_reg * e_ad_reg[16:0];
            f_pxh_reg  <= e_ax_reg * e_ad_reg[DEN_W-1:17];
            f_pyl_reg  <= e_ay_reg * e_ad_reg[16:0];
            f_pyh_reg  <= e_ay_reg * e_ad_reg[DEN_W-1:17];
            f_den_reg  <= e_den_reg;
            f_ctl_reg  <= e_ctl_reg;
            g_numx_reg <= NUM_W'(f_pxl_reg) + NUM_W'({f_pxh_reg, 17'b0});
            g_numy_reg <= NUM_W'(f_pyl_reg) + NUM_W'({f_pyh_reg, 17'b0});
            g_den_reg  <= f_den_reg;
            g_ctl_reg  <= f_ctl_reg;
        end
    end

    dcs_div u_div_tx
    (
        .clk (clk),
        .en  (en),
        .num (g_numx_reg),
        .den (g_den_reg),
        .quo (tx),
        .rem (rx_unused)
    );

    dcs_div u_div_ty
    (
        .clk (clk),
        .en  (en),
        .num (g_numy_reg),
        .den (g_den_reg),
        .quo (ty),
        .rem (ry_unused)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_dly_reg[0] <= g_ctl_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                ctl_dly_reg[i] <= ctl_dly_reg[i-1];
        end
    end

    // stage h: mass share numerators
    assign h_ctl = ctl_dly_reg[DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_px_reg           <= NUM_W'(tx) * NUM_W'(h_ctl.m1);
            h_py_reg           <= NUM_W'(ty) * NUM_W'(h_ctl.m1);
            h_sum_reg          <= DEN_W'(SUM_W'(h_ctl.m1) + SUM_W'(h_ctl.m2));
            h_wgt_reg.tx       <= tx;
            h_wgt_reg.ty       <= ty;
            h_wgt_reg.nx       <= h_ctl.nx;
            h_wgt_reg.ny       <= h_ctl.ny;
            h_wgt_reg.weighted <= h_ctl.weighted;
            h_wgt_reg.skip     <= h_ctl.skip;
            h_wgt_reg.broken   <= h_ctl.broken;
        end
    end

    dcs_div u_div_wx
    (
        .clk (clk),
        .en  (en),
        .num (h_px_reg),
        .den (h_sum_reg),
        .quo (qx),
        .rem (rx)
    );

    dcs_div u_div_wy
    (
        .clk (clk),
        .en  (en),
        .num (h_py_reg),
        .den (h_sum_reg),
        .quo (qy),
        .rem (ry)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wgt_dly_reg[0] <= h_wgt_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                wgt_dly_reg[i] <= wgt_dly_reg[i-1];
        end
    end

    // stage i: when weighted, body one takes the complement share, rounded down
    assign i_wgt = wgt_dly_reg[DIV_STEPS-1];
    assign w2x   = i_wgt.weighted ? qx : i_wgt.tx;
    assign w2y   = i_wgt.weighted ? qy : i_wgt.ty;
    assign w1x   = i_wgt.weighted ? (i_wgt.tx - qx - QUO_W'(rx != '0)) : i_wgt.tx;
    assign w1y   = i_wgt.weighted ? (i_wgt.ty - qy - QUO_W'(ry != '0)) : i_wgt.ty;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_mfx_reg    <= i_wgt.skip ? '0 : sat32(!i_wgt.nx && (w1x != '0), w1x);
            o_mfy_reg    <= i_wgt.skip ? '0 : sat32(!i_wgt.ny && (w1y != '0), w1y);
            o_msx_reg    <= i_wgt.skip ? '0 : sat32(i_wgt.nx && (w2x != '0), w2x);
            o_msy_reg    <= i_wgt.skip ? '0 : sat32(i_wgt.ny && (w2y != '0), w2y);
            o_broken_reg <= i_wgt.broken;
            o_moved_reg  <= !i_wgt.skip;
        end
    end

    assign move.valid         = vld_reg[LATENCY-1];
    assign move.move_first_x  = o_mfx_reg;
    assign move.move_first_y  = o_mfy_reg;
    assign move.move_second_x = o_msx_reg;
    assign move.move_second_y = o_msy_reg;
    assign move.broken        = o_broken_reg;
    assign move.moved         = o_moved_reg;

    // all four moves are zero
    assign o_zero = (o_mfx_reg | o_mfy_reg | o_msx_reg | o_msy_reg) == '0;

    // checks
    `DCS_ASSERT_SAME(a_still_zero, move.valid && !move.moved, o_zero)
    `DCS_ASSERT_SAME(a_broken_still, move.valid && move.broken, !move.moved)
    `DCS_ASSERT_SAME(a_stall_blocks, move.valid && !move.ready, !link.ready)
    `DCS_ASSERT_NEXT(a_accept_enters, link.valid && link.ready, vld_reg[0])

endmodule

// ===== hdl/dcs_sqrt.sv =====
module dcs_sqrt import dcs_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   rad,
    output logic [ROOT_W-1:0] root
);

    logic [ROOT_W+1:0] rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS];
    logic [SQ_W-1:0]   rad_reg  [SQRT_STEPS];

    // one root bit per stage, msb first
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_step
        logic [ROOT_W+1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        logic [ROOT_W+3:0] acc;
        logic [ROOT_W+3:0] trial;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        assign acc   = {rem_in, rad_in[SQ_W-1:SQ_W-2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (acc >= trial)
                begin
                    rem_reg[i]  <= (ROOT_W+2)'(acc - trial);
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= acc[ROOT_W+1:0];
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                rad_reg[i] <= {rad_in[SQ_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ===== hdl/dcs_div.sv =====
module dcs_div import dcs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    logic [DEN_W-1:0] rem_reg [DIV_STEPS];
    logic [QUO_W-1:0] low_reg [DIV_STEPS];
    logic [DEN_W-1:0] den_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   acc;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign acc = {rem_in, low_in[QUO_W-1]};
        assign ge  = acc >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? DEN_W'(acc - {1'b0, den_in}) : acc[DEN_W-1:0];
                quo_reg[i] <= {quo_in[QUO_W-2:0], ge};
                low_reg[i] <= {low_in[QUO_W-2:0], 1'b0};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];
    assign rem = rem_reg[DIV_STEPS-1];

endmodule

// ===== dv/dcs_tb_if.sv =====
`timescale 1ns / 100ps

// the block's own channel interfaces live with the rtl; this file holds the
// watchdog-free helper interface that carries only the bench's long_hold run control
interface dcs_tb_ctl_if ();
    logic long_hold;
endinterface

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic [30:0]        rest;
        logic [15:0]        fac;
        logic               tension;
    } link_t;

    typedef struct {
        logic [31:0] mfx;
        logic [31:0] mfy;
        logic [31:0] msx;
        logic [31:0] msy;
        logic        broken;
        logic        moved;
    } move_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_cycles;
    int   rx_count;
    int   long_stall;
    int   stall_max;
    int   gap_max;
    move_t expected_moves[$];

    dcs_link_if link ();
    dcs_move_if move ();
    dcs_tb_ctl_if ctl ();

    distance_constraint_solver_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .link  (link.sink),
        .move  (move.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor square root of a 68 bit sum
    function automatic logic [34:0] isqrt(input logic [67:0] s);
        logic [34:0] r;
        logic [34:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            c = r | (35'd1 << b);
            if ({35'd0, c} * {35'd0, c} <= {2'd0, s})
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp(input logic neg, input logic [63:0] mag);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    endfunction

    // expected displacement for one constraint
    function automatic move_t solve_constraint(input link_t c);
        move_t r;
        logic signed [33:0] vx, vy;
        logic [33:0]        ax, ay;
        logic [67:0]        sq;
        logic [34:0]        span;
        logic signed [36:0] delta;
        logic [36:0]        ad;
        logic [127:0]       tx, ty;
        logic [63:0]        w1x, w1y, w2x, w2y;
        logic [63:0]        sum;
        logic               nx, ny;
        r = '{default: '0};
        vx = 34'(c.fx) - 34'(c.sx);
        vy = 34'(c.fy) - 34'(c.sy);
        ax = vx[33] ? 34'(-vx) : vx;
        ay = vy[33] ? 34'(-vy) : vy;
        sq = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
        span = isqrt(sq);
        if (c.fac != 0 && (64'(span) << 8) > 64'(c.rest) * 64'(c.fac))
        begin
            r.broken = 1'b1;
            return r;
        end
        if (span == 0)
            return r;
        delta = 37'(span) - 37'(c.rest);
        if (c.tension && delta <= 0)
            return r;
        ad = delta[36] ? 37'(-delta) : delta;
        tx = (128'(ax) * 128'(ad)) / (128'(span) << 1);
        ty = (128'(ay) * 128'(ad)) / (128'(span) << 1);
        nx = vx[33] != delta[36];
        ny = vy[33] != delta[36];
        if (c.m1 != 0 && c.m2 != 0 && !delta[36])
        begin
            sum = 64'(c.m1) + 64'(c.m2);
            w2x = tx[63:0] * c.m1 / sum;
            w2y = ty[63:0] * c.m1 / sum;
            w1x = tx[63:0] * c.m2 / sum;
            w1y = ty[63:0] * c.m2 / sum;
        end
        else
        begin
            w1x = tx[63:0];
            w2x = tx[63:0];
            w1y = ty[63:0];
            w2y = ty[63:0];
        end
        r.mfx = clamp(!nx && w1x != 0, w1x);
        r.mfy = clamp(!ny && w1y != 0, w1y);
        r.msx = clamp(nx && w2x != 0, w2x);
        r.msy = clamp(ny && w2y != 0, w2y);
        r.moved = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int pick_gap(input int cap);
        if (cap == 0 || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, cap * 8);
        return $urandom_range(0, cap);
    endfunction

    // send one constraint and record its expected moves
    task automatic send_link(input link_t c);
        int gap;
        gap = pick_gap(gap_max);
        repeat (gap)
        begin
            link.valid <= 1'b0;
            @(posedge clk);
        end
        link.valid        <= 1'b1;
        link.first_x      <= c.fx;
        link.first_y      <= c.fy;
        link.second_x     <= c.sx;
        link.second_y     <= c.sy;
        link.first_mass   <= c.m1;
        link.second_mass  <= c.m2;
        link.rest_length  <= c.rest;
        link.max_stretch  <= c.fac;
        link.tension_only <= c.tension;
        @(posedge clk);
        while (!link.ready)
            @(posedge clk);
        expected_moves.push_back(solve_constraint(c));
    endtask

    task automatic end_link();
        link.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            3: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
            default: return $urandom;
        endcase
    endfunction

    // mostly plausible constraints with sizable length error
    function automatic link_t rand_link();
        link_t c;
        c.fx = rand_pos();
        c.fy = rand_pos();
        c.sx = ($urandom_range(0, 9) == 0) ? c.fx : rand_pos();
        c.sy = ($urandom_range(0, 9) == 0) ? c.fy : rand_pos();
        c.m1 = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
        c.m2 = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
        c.rest = ($urandom_range(0, 1) == 0) ? 31'($urandom_range(0, 32'h0400_0000))
                                               : 31'($urandom);
        c.fac = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        c.tension = $urandom_range(0, 1);
        return c;
    endfunction

    function automatic link_t make_link(input logic [31:0] fx, fy, sx, sy,
                                        input logic [15:0] m1, m2,
                                        input logic [30:0] rest,
                                        input logic [15:0] fac, input logic t);
        link_t c;
        c.fx = fx;
        c.fy = fy;
        c.sx = sx;
        c.sy = sy;
        c.m1 = m1;
        c.m2 = m2;
        c.rest = rest;
        c.fac = fac;
        c.tension = t;
        return c;
    endfunction

    // extremes, every special case, back to back
    task automatic test_directed();
        gap_max = 0;
        send_link(make_link(0, 0, 0, 0, 256, 256, 0, 0, 0));
        send_link(make_link(32'h10000, 0, 0, 0, 256, 256, 0, 0, 0));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 512, 32'h20000, 0, 0));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 512, 32'h80000, 0, 0));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 512, 32'h80000, 0, 1));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 512, 32'h50000, 0, 1));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 0, 512, 32'h10000, 0, 0));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 0, 32'h10000, 0, 1));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 256, 32'h10000, 16'h0200, 0));
        send_link(make_link(32'h30000, 32'h40000, 0, 0, 256, 256, 32'h20000, 16'h0280, 0));
        send_link(make_link(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                            16'hffff, 16'hffff, 0, 0, 0));
        send_link(make_link(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            0, 0, 0, 0, 1));
        send_link(make_link(32'h80000000, 0, 32'h7fffffff, 0,
                            16'hffff, 1, 31'h7fffffff, 16'hffff, 0));
        send_link(make_link(0, 32'h7fffffff, 0, 32'h80000000,
                            1, 16'hffff, 31'h7fffffff, 0, 0));
        send_link(make_link(5, 5, 5, 5, 0, 0, 31'h7fffffff, 16'hffff, 1));
        send_link(make_link(1, 0, 0, 0, 16'hffff, 16'hffff, 31'h7fffffff, 16'hffff, 0));
        send_link(make_link(32'hfffe0000, 32'h20000, 32'h20000, 32'hfffe0000,
                            16'h0100, 16'h0300, 31'h7fffffff, 16'h0001, 0));
        send_link(make_link(32'h1234, 32'h5678, 32'hffff0000, 32'h9abc,
                            16'h0080, 16'h0100, 0, 16'h0100, 0));
        end_link();
    endtask

    task automatic test_random(input int count, input int cap);
        gap_max = cap;
        repeat (count)
            send_link(rand_link());
        end_link();
    endtask

    // receiver holds off long enough to fill the pipeline
    task automatic test_backpressure();
        ctl.long_hold = 1'b1;
        gap_max = 0;
        fork
            begin
                repeat (400) @(posedge clk);
                ctl.long_hold = 1'b0;
            end
            begin
                repeat (300)
                    send_link(rand_link());
                end_link();
            end
        join
    endtask

    task automatic drain();
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    // receiver ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move.ready <= 1'b0;
            long_stall <= 0;
        end
        else if (ctl.long_hold)
            move.ready <= 1'b0;
        else if (long_stall > 0)
        begin
            move.ready <= 1'b0;
            long_stall <= long_stall - 1;
        end
        else if (stall_max != 0 && $urandom_range(0, 3) == 0)
        begin
            move.ready <= 1'b0;
            long_stall <= ($urandom_range(0, 15) == 0) ? $urandom_range(0, stall_max * 8)
                                                       : $urandom_range(0, stall_max);
        end
        else
            move.ready <= 1'b1;
    end

    // result check
    always @(posedge clk)
    begin
        move_t want;
        if (rst_n && move.valid && move.ready)
        begin
            rx_count++;
            if (expected_moves.size() == 0)
                report_mismatch("unexpected move transaction", 32'(move.moved), 32'd0);
            else
            begin
                want = expected_moves.pop_front();
                if (move.move_first_x !== want.mfx)
                    report_mismatch("move_first_x", move.move_first_x, want.mfx);
                if (move.move_first_y !== want.mfy)
                    report_mismatch("move_first_y", move.move_first_y, want.mfy);
                if (move.move_second_x !== want.msx)
                    report_mismatch("move_second_x", move.move_second_x, want.msx);
                if (move.move_second_y !== want.msy)
                    report_mismatch("move_second_y", move.move_second_y, want.msy);
                if (move.broken !== want.broken)
                    report_mismatch("broken", 32'(move.broken), 32'(want.broken));
                if (move.moved !== want.moved)
                    report_mismatch("moved", 32'(move.moved), 32'(want.moved));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((link.valid && link.ready) || (move.valid && move.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        rx_count = 0;
        stall_max = 0;
        gap_max = 0;
        ctl.long_hold = 1'b0;
        rst_n = 1'b0;
        link.valid = 1'b0;
        link.first_x = '0;
        link.first_y = '0;
        link.second_x = '0;
        link.second_y = '0;
        link.first_mass = '0;
        link.second_mass = '0;
        link.rest_length = '0;
        link.max_stretch = '0;
        link.tension_only = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(500, 0);
        stall_max = 6;
        test_random(600, 6);
        test_backpressure();
        stall_max = 3;
        test_random(350, 2);
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
